FILE: rtl/lrcc_pkg.sv
// Shared types, widths and codes for the line raster with circle clip.
package lrcc_pkg;

  localparam int COORD_BITS = 16;
  localparam int RAD_W      = 13;
  localparam int CLR_W      = 32;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int DYN_W      = COORD_BITS + 2;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int MAG_W      = (DELTA_W > RAD_W) ? DELTA_W : RAD_W;
  localparam int CHK_W      = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int SUM_W      = SQ_W + 1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(768);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_POINT     = 2'd0,
    ST_LOAD_OK   = 2'd1,
    ST_LOAD_REJ  = 2'd2,
    ST_IDLE_STEP = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    coord_t           start_x;
    coord_t           start_y;
    coord_t           end_x;
    coord_t           end_y;
    coord_t           centre_x;
    coord_t           centre_y;
    logic [RAD_W-1:0] radius;
    logic [CLR_W-1:0] colour;
  } in_t;

  typedef struct packed {
    coord_t           pixel_x;
    coord_t           pixel_y;
    logic [CLR_W-1:0] pixel_colour;
    logic             draw;
    logic             last;
    status_e          status;
  } out_t;

  // After the line step: result minus draw, plus circle distances.
  typedef struct packed {
    out_t             pix;
    logic             near;
    logic [RAD_W-1:0] ax;
    logic [RAD_W-1:0] ay;
    logic [RAD_W-1:0] r;
  } s1_t;

  // After the squares.
  typedef struct packed {
    out_t            pix;
    logic            near;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_r;
  } s2_t;

  function automatic logic in_range(coord_t v, logic [DIM_W-1:0] lim);
    logic [CHK_W-1:0] a;
    logic [CHK_W-1:0] b;
    a = CHK_W'($unsigned(v));
    b = CHK_W'(lim);
    return !v[COORD_BITS-1] && (a < b);
  endfunction

endpackage

FILE: rtl/lrcc_step.sv
// Line state, load check and Bresenham step.
module lrcc_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lrcc_pkg::in_t                 in_i,
  input  logic [lrcc_pkg::DIM_W-1:0]    width_i,
  input  logic [lrcc_pkg::DIM_W-1:0]    height_i,
  output logic                          s1_valid_o,
  input  logic                          s1_ready_i,
  output lrcc_pkg::s1_t                 s1_o
);

  lrcc_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  lrcc_pkg::coord_t target_x_q, target_x_d, target_y_q, target_y_d;
  lrcc_pkg::coord_t circle_x_q, circle_x_d, circle_y_q, circle_y_d;
  logic step_neg_x_q, step_neg_x_d, step_neg_y_q, step_neg_y_d;
  logic signed [lrcc_pkg::DELTA_W-1:0] delta_x_q, delta_x_d;
  logic signed [lrcc_pkg::DYN_W-1:0]   delta_y_neg_q, delta_y_neg_d;
  logic signed [lrcc_pkg::ERR_W-1:0]   error_q, error_d;
  logic [lrcc_pkg::RAD_W-1:0] circle_r_q, circle_r_d;
  logic [lrcc_pkg::CLR_W-1:0] colour_q, colour_d;
  logic active_q, active_d;

  logic s1_valid_q;
  lrcc_pkg::s1_t s1_q, s1_d;
  logic accept;

  logic signed [lrcc_pkg::DELTA_W-1:0] ddx, ddy, adx, ady, cdx, cdy;
  logic [lrcc_pkg::MAG_W-1:0] magx, magy, rad_ext;
  logic signed [lrcc_pkg::ERR_W:0] e2;
  logic signed [lrcc_pkg::ERR_W-1:0] err_n;
  logic load_ok, last, mv_x, mv_y;
  lrcc_pkg::coord_t one;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;
  assign one        = lrcc_pkg::coord_t'(1);

  always_comb begin
    ddx = lrcc_pkg::DELTA_W'(in_i.end_x) - lrcc_pkg::DELTA_W'(in_i.start_x);
    ddy = lrcc_pkg::DELTA_W'(in_i.end_y) - lrcc_pkg::DELTA_W'(in_i.start_y);
    adx = ddx[lrcc_pkg::DELTA_W-1] ? -ddx : ddx;
    ady = ddy[lrcc_pkg::DELTA_W-1] ? -ddy : ddy;
    load_ok = lrcc_pkg::in_range(in_i.start_x, width_i)
           && lrcc_pkg::in_range(in_i.start_y, height_i)
           && lrcc_pkg::in_range(in_i.end_x, width_i)
           && lrcc_pkg::in_range(in_i.end_y, height_i);

    // distance of the current point from the circle centre, per axis
    cdx = lrcc_pkg::DELTA_W'(cur_x_q) - lrcc_pkg::DELTA_W'(circle_x_q);
    cdy = lrcc_pkg::DELTA_W'(cur_y_q) - lrcc_pkg::DELTA_W'(circle_y_q);
    magx = lrcc_pkg::MAG_W'($unsigned(cdx[lrcc_pkg::DELTA_W-1] ? -cdx : cdx));
    magy = lrcc_pkg::MAG_W'($unsigned(cdy[lrcc_pkg::DELTA_W-1] ? -cdy : cdy));
    rad_ext = lrcc_pkg::MAG_W'(circle_r_q);

    // both axis decisions use the doubled error from before either move
    e2   = $signed({error_q, 1'b0});
    last = 1'b0;
    mv_x = 1'b0;
    mv_y = 1'b0;
    if (cur_x_q == target_x_q && cur_y_q == target_y_q) begin
      last = 1'b1;
    end else begin
      if (e2 >= (lrcc_pkg::ERR_W + 1)'(delta_y_neg_q)) begin
        if (cur_x_q == target_x_q) last = 1'b1;
        else mv_x = 1'b1;
      end
      if (!last && e2 <= (lrcc_pkg::ERR_W + 1)'(delta_x_q)) begin
        if (cur_y_q == target_y_q) last = 1'b1;
        else mv_y = 1'b1;
      end
    end
    err_n = error_q;
    if (mv_x) err_n = err_n + lrcc_pkg::ERR_W'(delta_y_neg_q);
    if (mv_y) err_n = err_n + lrcc_pkg::ERR_W'(delta_x_q);

    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    target_x_d    = target_x_q;
    target_y_d    = target_y_q;
    circle_x_d    = circle_x_q;
    circle_y_d    = circle_y_q;
    circle_r_d    = circle_r_q;
    step_neg_x_d  = step_neg_x_q;
    step_neg_y_d  = step_neg_y_q;
    delta_x_d     = delta_x_q;
    delta_y_neg_d = delta_y_neg_q;
    error_d       = error_q;
    colour_d      = colour_q;
    active_d      = active_q;
    s1_d          = '0;

    if (accept) begin
      if (in_i.op == lrcc_pkg::OP_LOAD) begin
        if (load_ok) begin
          cur_x_d       = in_i.start_x;
          cur_y_d       = in_i.start_y;
          target_x_d    = in_i.end_x;
          target_y_d    = in_i.end_y;
          step_neg_x_d  = !(in_i.start_x < in_i.end_x);
          step_neg_y_d  = !(in_i.start_y < in_i.end_y);
          delta_x_d     = adx;
          delta_y_neg_d = -lrcc_pkg::DYN_W'(ady);
          error_d       = lrcc_pkg::ERR_W'(adx) - lrcc_pkg::ERR_W'(ady);
          circle_x_d    = in_i.centre_x;
          circle_y_d    = in_i.centre_y;
          circle_r_d    = in_i.radius;
          colour_d      = in_i.colour;
          active_d      = 1'b1;
          s1_d.pix.status = lrcc_pkg::ST_LOAD_OK;
        end else begin
          active_d        = 1'b0;
          s1_d.pix.status = lrcc_pkg::ST_LOAD_REJ;
        end
      end else if (!active_q) begin
        s1_d.pix.status = lrcc_pkg::ST_IDLE_STEP;
      end else begin
        s1_d.pix.pixel_x      = cur_x_q;
        s1_d.pix.pixel_y      = cur_y_q;
        s1_d.pix.pixel_colour = colour_q;
        s1_d.pix.last         = last;
        s1_d.pix.status       = lrcc_pkg::ST_POINT;
        s1_d.near = (magx <= rad_ext) && (magy <= rad_ext);
        s1_d.ax   = magx[lrcc_pkg::RAD_W-1:0];
        s1_d.ay   = magy[lrcc_pkg::RAD_W-1:0];
        s1_d.r    = circle_r_q;
        error_d   = err_n;
        if (last) begin
          active_d = 1'b0;
        end else begin
          cur_x_d = mv_x ? (step_neg_x_q ? cur_x_q - one : cur_x_q + one) : cur_x_q;
          cur_y_d = mv_y ? (step_neg_y_q ? cur_y_q - one : cur_y_q + one) : cur_y_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      target_x_q    <= '0;
      target_y_q    <= '0;
      circle_x_q    <= '0;
      circle_y_q    <= '0;
      circle_r_q    <= '0;
      step_neg_x_q  <= 1'b0;
      step_neg_y_q  <= 1'b0;
      delta_x_q     <= '0;
      delta_y_neg_q <= '0;
      error_q       <= '0;
      colour_q      <= '0;
      active_q      <= 1'b0;
      s1_valid_q    <= 1'b0;
    end else begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      target_x_q    <= target_x_d;
      target_y_q    <= target_y_d;
      circle_x_q    <= circle_x_d;
      circle_y_q    <= circle_y_d;
      circle_r_q    <= circle_r_d;
      step_neg_x_q  <= step_neg_x_d;
      step_neg_y_q  <= step_neg_y_d;
      delta_x_q     <= delta_x_d;
      delta_y_neg_q <= delta_y_neg_d;
      error_q       <= error_d;
      colour_q      <= colour_d;
      active_q      <= active_d;
      if (in_ready_o) s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= s1_d;
  end

  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.op == lrcc_pkg::OP_STEP && active_q && last |=> !active_q)
    else $error("line still active after its last point");

  a_step_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.op == lrcc_pkg::OP_STEP && active_q && !last |=> active_q)
    else $error("line dropped before its last point");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.op == lrcc_pkg::OP_STEP && !active_q
    |=> s1_q.pix.status == lrcc_pkg::ST_IDLE_STEP && !active_q)
    else $error("step while idle not flagged");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ready_i |=> s1_valid_q && $stable(s1_q))
    else $error("stage one transaction lost while stalled");

endmodule

FILE: rtl/lrcc_circle.sv
// Clip circle test: squares in one stage, sum and compare in the result stage.
module lrcc_circle (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s1_valid_i,
  output logic          s1_ready_o,
  input  lrcc_pkg::s1_t s1_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lrcc_pkg::out_t out_o
);

  logic s2_valid_q, s2_ready;
  lrcc_pkg::s2_t s2_q, s2_d;
  logic out_valid_q;
  lrcc_pkg::out_t out_q, out_d;
  logic [lrcc_pkg::SUM_W-1:0] sum;

  assign s2_ready    = !out_valid_q || out_ready_i;
  assign s1_ready_o  = !s2_valid_q || s2_ready;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    s2_d      = '0;
    s2_d.pix  = s1_i.pix;
    s2_d.near = s1_i.near;
    s2_d.sq_x = lrcc_pkg::SQ_W'(s1_i.ax) * lrcc_pkg::SQ_W'(s1_i.ax);
    s2_d.sq_y = lrcc_pkg::SQ_W'(s1_i.ay) * lrcc_pkg::SQ_W'(s1_i.ay);
    s2_d.sq_r = lrcc_pkg::SQ_W'(s1_i.r) * lrcc_pkg::SQ_W'(s1_i.r);
  end

  always_comb begin
    sum        = lrcc_pkg::SUM_W'(s2_q.sq_x) + lrcc_pkg::SUM_W'(s2_q.sq_y);
    out_d      = s2_q.pix;
    out_d.draw = s2_q.near && (sum <= lrcc_pkg::SUM_W'(s2_q.sq_r));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready_o) s2_valid_q <= s1_valid_i;
      if (s2_ready) out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) s2_q <= s2_d;
    if (s2_valid_q && s2_ready) out_q <= out_d;
  end

  a_draw_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.draw |-> out_q.status == lrcc_pkg::ST_POINT)
    else $error("draw set on a non-point result");

  a_s2_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_ready |=> out_valid_q)
    else $error("square stage transaction dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");

endmodule

FILE: rtl/line_raster_circle_clip.sv
// Top level: image size registers, line stepper and circle clip pipeline.
// Bresenham line rasterizer with a circular clip region. Every input
// transaction, load or step, yields exactly one result transaction, and a
// new transaction is taken every clock while the output keeps draining;
// each passes the stage-one, squares and result registers. Line position,
// error term and end test are worked out combinationally on acceptance,
// which allows one point per clock; the inside-circle flag follows in two
// more stages (squares, then sum and compare). Image size registers gate
// only load transactions; the user writes them (cfg_we_i, cfg_idx_i,
// cfg_data_i) only while the block is idle, which it does not enforce.
module line_raster_circle_clip (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lrcc_pkg::in_t                     in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lrcc_pkg::out_t                    out_o,
  input  logic                              cfg_we_i,
  input  logic [lrcc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lrcc_pkg::DIM_W-1:0]        cfg_data_i
);

  logic [lrcc_pkg::DIM_W-1:0] width_q, height_q;
  logic s1_valid, s1_ready;
  lrcc_pkg::s1_t s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lrcc_pkg::WIDTH_RST;
      height_q <= lrcc_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (lrcc_pkg::cfg_idx_e'(cfg_idx_i))
        lrcc_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        lrcc_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrcc_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_o       (s1)
  );

  lrcc_circle u_circle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_i        (s1),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
